### design/sh24_pkg.sv
// sh24_pkg: shared types, SipHash constants, the round function and the
// microcode ROM of the chained SipHash-2-4 engine. No dependencies.
`default_nettype none

package sh24_pkg;

	localparam logic [63:0] INIT_A    = 64'h736f6d6570736575;
	localparam logic [63:0] INIT_B    = 64'h646f72616e646f6d;
	localparam logic [63:0] INIT_C    = 64'h6c7967656e657261;
	localparam logic [63:0] INIT_D    = 64'h7465646279746573;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	// configuration register indexes
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef logic [3:0] step_t;

	// microprogram addresses
	localparam step_t STEP_CHAIN1 = 4'd0;
	localparam step_t STEP_CHAIN2 = 4'd1;
	localparam step_t STEP_WORD1  = 4'd2;
	localparam step_t STEP_WORD2  = 4'd3;
	localparam step_t STEP_LEN1   = 4'd4;
	localparam step_t STEP_LEN2   = 4'd5;
	localparam step_t STEP_FIN1   = 4'd6;
	localparam step_t STEP_FIN2   = 4'd7;
	localparam step_t STEP_FIN3   = 4'd8;
	localparam step_t STEP_FIN4   = 4'd9;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} lanes_t;

	typedef enum logic [1:0] {
		MSG_NONE,
		MSG_CHAIN,
		MSG_WORD,
		MSG_LEN
	} msg_sel_t;

	typedef enum logic [2:0] {
		BR_NEXT,   // go to nxt
		BR_SHORT,  // short last word: go to alt, else nxt
		BR_LAST,   // last word: go to nxt, else end without digest
		BR_EMIT,   // end and load the digest register
		BR_END     // end without digest
	} br_t;

	// control word seen by the lane datapath
	typedef struct packed {
		logic en;
		logic init;
		logic xor_d;
		logic xor_c_ff;
		logic xor_a;
	} dp_ctrl_t;

	typedef struct packed {
		logic     init;
		msg_sel_t msg_sel;
		logic     xor_d;
		logic     xor_c_ff;
		logic     xor_a;
		br_t      br;
		step_t    nxt;
		step_t    alt;
	} ucode_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

	function automatic lanes_t sip_round(input lanes_t v);
		lanes_t w;
		w = v;
		w.a = w.a + w.b; w.b = rotl(w.b, 13); w.b = w.b ^ w.a; w.a = rotl(w.a, 32);
		w.c = w.c + w.d; w.d = rotl(w.d, 16); w.d = w.d ^ w.c;
		w.a = w.a + w.d; w.d = rotl(w.d, 21); w.d = w.d ^ w.a;
		w.c = w.c + w.b; w.b = rotl(w.b, 17); w.b = w.b ^ w.c; w.c = rotl(w.c, 32);
		return w;
	endfunction

	// microcode ROM: every step runs one SipRound
	function automatic ucode_t ucode(input step_t s);
		ucode_t u;
		u = '{init: 1'b0, msg_sel: MSG_NONE, xor_d: 1'b0, xor_c_ff: 1'b0,
			xor_a: 1'b0, br: BR_END, nxt: STEP_CHAIN1, alt: STEP_CHAIN1};
		case (s)
			STEP_CHAIN1: begin
				u.init = 1'b1; u.msg_sel = MSG_CHAIN; u.xor_d = 1'b1;
				u.br = BR_NEXT; u.nxt = STEP_CHAIN2;
			end
			STEP_CHAIN2: begin
				u.msg_sel = MSG_CHAIN; u.xor_a = 1'b1;
				u.br = BR_SHORT; u.nxt = STEP_WORD1; u.alt = STEP_LEN1;
			end
			STEP_WORD1: begin
				u.msg_sel = MSG_WORD; u.xor_d = 1'b1;
				u.br = BR_NEXT; u.nxt = STEP_WORD2;
			end
			STEP_WORD2: begin
				u.msg_sel = MSG_WORD; u.xor_a = 1'b1;
				u.br = BR_LAST; u.nxt = STEP_LEN1;
			end
			STEP_LEN1: begin
				u.msg_sel = MSG_LEN; u.xor_d = 1'b1;
				u.br = BR_NEXT; u.nxt = STEP_LEN2;
			end
			STEP_LEN2: begin
				u.msg_sel = MSG_LEN; u.xor_a = 1'b1;
				u.br = BR_NEXT; u.nxt = STEP_FIN1;
			end
			STEP_FIN1: begin
				u.xor_c_ff = 1'b1; u.br = BR_NEXT; u.nxt = STEP_FIN2;
			end
			STEP_FIN2: begin
				u.br = BR_NEXT; u.nxt = STEP_FIN3;
			end
			STEP_FIN3: begin
				u.br = BR_NEXT; u.nxt = STEP_FIN4;
			end
			STEP_FIN4: begin
				u.br = BR_EMIT;
			end
			default: begin
				u.br = BR_END;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

### design/sh24_lanes.sv
// sh24_lanes: the four SipHash lane registers around one SipRound.
// Depends on sh24_pkg for the lane type, constants and round function.
`default_nettype none

module sh24_lanes (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sh24_pkg::dp_ctrl_t  ctrl,
	input  wire logic [63:0]         msg,
	input  wire logic [63:0]         key_low,
	input  wire logic [63:0]         key_high,
	output logic [63:0]              fold
);

	sh24_pkg::lanes_t lanes_q;
	sh24_pkg::lanes_t src;
	sh24_pkg::lanes_t rnd;
	sh24_pkg::lanes_t nxt;

	always_comb begin
		if (ctrl.init) begin
			src.a = sh24_pkg::INIT_A ^ key_low;
			src.b = sh24_pkg::INIT_B ^ key_high;
			src.c = sh24_pkg::INIT_C ^ key_low;
			src.d = sh24_pkg::INIT_D ^ key_high;
		end else begin
			src = lanes_q;
		end
		if (ctrl.xor_d) begin
			src.d = src.d ^ msg;
		end
		if (ctrl.xor_c_ff) begin
			src.c = src.c ^ sh24_pkg::FINAL_XOR;
		end
		rnd = sh24_pkg::sip_round(src);
		nxt = rnd;
		if (ctrl.xor_a) begin
			nxt.a = rnd.a ^ msg;
		end
	end

	// digest of the lanes as they leave this round
	assign fold = nxt.a ^ nxt.b ^ nxt.c ^ nxt.d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= '0;
		end else if (ctrl.en) begin
			lanes_q <= nxt;
		end
	end

endmodule

`default_nettype wire

### design/siphash24_chained_digest.sv
// siphash24_chained_digest: chained SipHash-2-4 engine, microcode sequencer.
// Depends on sh24_pkg and sh24_lanes.
`default_nettype none

// One 64-bit message word per input handshake; a word with first_word set
// loads the lanes from the key and absorbs chain_in ahead of its bytes. The
// lane datapath does one SipRound per cycle, save while the last step waits
// for the digest register, under a ten-step microprogram: a middle word runs
// WORD1-2, a first word adds CHAIN1-2, and a last word adds the length block
// and four finalization rounds, in place of WORD1-2 when it holds fewer than
// 8 bytes. The next word is accepted in the cycle the current one ends. The
// digest sits in an output register; the engine stalls only if a second
// digest is ready while the first has not been taken. Keys are written
// through the config port while the engine is idle (cfg_ready low when busy).
module siphash24_chained_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	// input word channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        first_word,
	input  wire logic [63:0] chain_in,
	input  wire logic [63:0] message_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last_word,
	// digest channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      digest
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;

	// sequencer state
	logic                busy_q;
	sh24_pkg::step_t     step_q;
	sh24_pkg::ucode_t    uc;
	logic                can_load;
	logic                run;
	logic                end_now;
	sh24_pkg::step_t     step_nxt;

	// word held for the current item
	logic        last_q;
	logic        full_q;
	logic [63:0] word_q;
	logic [63:0] chain_q;
	logic [7:0]  len_q;

	logic        in_acc;
	logic        in_full;
	logic        in_short_last;
	logic [3:0]  in_cnt;
	logic [63:0] in_masked;

	logic [63:0]          msg;
	sh24_pkg::dp_ctrl_t   dp_ctrl;
	logic [63:0]          fold;

	logic        out_valid_q;
	logic [63:0] digest_q;

	// ---------------------------------------------------------------
	// config registers
	// ---------------------------------------------------------------
	assign cfg_ready = ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sh24_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				sh24_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// input decode: counts above 8 act as 8, mask unused bytes
	// ---------------------------------------------------------------
	assign in_full       = byte_count[3];
	assign in_cnt        = in_full ? 4'd8 : byte_count;
	assign in_short_last = last_word & ~in_full;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			in_masked[8*i +: 8] = (in_full || (byte_count[2:0] > 3'(i)))
				? message_word[8*i +: 8] : 8'h00;
		end
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	assign uc       = sh24_pkg::ucode(step_q);
	assign can_load = ~out_valid_q | ~out_stall;
	// hold the final step until the digest register is free
	assign run      = busy_q & ((uc.br != sh24_pkg::BR_EMIT) | can_load);

	always_comb begin
		end_now  = 1'b0;
		step_nxt = uc.nxt;
		case (uc.br)
			sh24_pkg::BR_NEXT: begin
				step_nxt = uc.nxt;
			end
			sh24_pkg::BR_SHORT: begin
				step_nxt = (last_q && !full_q) ? uc.alt : uc.nxt;
			end
			sh24_pkg::BR_LAST: begin
				end_now = ~last_q;
			end
			sh24_pkg::BR_EMIT: begin
				end_now = 1'b1;
			end
			sh24_pkg::BR_END: begin
				end_now = 1'b1;
			end
			default: begin
				end_now = 1'b1;
			end
		endcase
	end

	// take the next word in the cycle the current one finishes
	assign in_stall = busy_q & ~(run & end_now);
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= sh24_pkg::STEP_CHAIN1;
			len_q  <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				len_q  <= (first_word ? 8'd0 : len_q) + {4'd0, in_cnt};
				if (first_word) begin
					step_q <= sh24_pkg::STEP_CHAIN1;
				end else if (in_short_last) begin
					step_q <= sh24_pkg::STEP_LEN1;
				end else begin
					step_q <= sh24_pkg::STEP_WORD1;
				end
			end else if (run) begin
				if (end_now) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_nxt;
				end
			end
		end
	end

	// payload of the word in flight
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q  <= last_word;
			full_q  <= in_full;
			word_q  <= in_masked;
			chain_q <= chain_in;
		end
	end

	// ---------------------------------------------------------------
	// block select and lane datapath
	// ---------------------------------------------------------------
	always_comb begin
		case (uc.msg_sel)
			sh24_pkg::MSG_CHAIN: msg = chain_q;
			sh24_pkg::MSG_WORD:  msg = word_q;
			sh24_pkg::MSG_LEN:   msg = (full_q ? 64'd0 : word_q) | {len_q, 56'd0};
			default:             msg = '0;
		endcase
	end

	assign dp_ctrl = '{en: run, init: uc.init, xor_d: uc.xor_d,
		xor_c_ff: uc.xor_c_ff, xor_a: uc.xor_a};

	sh24_lanes u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dp_ctrl),
		.msg      (msg),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.fold     (fold)
	);

	// ---------------------------------------------------------------
	// digest register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run && uc.br == sh24_pkg::BR_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run && uc.br == sh24_pkg::BR_EMIT) begin
			digest_q <= fold;
		end
	end

	assign out_valid = out_valid_q;
	assign digest    = digest_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_emit_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(run && uc.br == sh24_pkg::BR_EMIT) |-> last_q)
		else $error("digest loaded for a word without last flag");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= sh24_pkg::STEP_FIN4))
		else $error("sequencer step outside the microprogram");

	a_digest_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("digest appeared without a word in flight");

endmodule

`default_nettype wire

### tb/sh24_digest_checker.sv
// sh24_digest_checker: follows key writes and word traffic of the chained
// SipHash-2-4 engine, predicts each digest and matches it on the output side.
// Depends on sh24_pkg for the lane init constants and register indexes.
`default_nettype none

module sh24_digest_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        first_word,
	input  wire logic [63:0] chain_in,
	input  wire logic [63:0] message_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last_word,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] digest,
	output int               mismatches,
	output int               digests_owed
);

	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [63:0] va;
	logic [63:0] vb;
	logic [63:0] vc;
	logic [63:0] vd;
	logic [7:0]  byte_total;
	logic [63:0] want;
	logic [63:0] expected_digests[$];
	int          fail_count = 0;

	function automatic logic [63:0] rotate_left(input logic [63:0] x, input int n);
		return (x << n) | (x >> (64 - n));
	endfunction

	task automatic sip_mix();
		va = va + vb; vb = rotate_left(vb, 13); vb = vb ^ va; va = rotate_left(va, 32);
		vc = vc + vd; vd = rotate_left(vd, 16); vd = vd ^ vc;
		va = va + vd; vd = rotate_left(vd, 21); vd = vd ^ va;
		vc = vc + vb; vb = rotate_left(vb, 17); vb = vb ^ vc; vc = rotate_left(vc, 32);
	endtask

	task automatic fold_block(input logic [63:0] m);
		vd = vd ^ m;
		sip_mix();
		sip_mix();
		va = va ^ m;
	endtask

	// advance the lanes by one accepted word; queue a digest when it ends a message
	task automatic hash_word(input logic f, input logic [63:0] chain, input logic [63:0] w,
			input logic [3:0] cnt, input logic l);
		logic [3:0]  n;
		logic [63:0] m;
		n = (cnt > 4'd8) ? 4'd8 : cnt;
		m = (n == 4'd8) ? w : (w & ((64'd1 << (8 * n)) - 64'd1));
		if (f) begin
			va = sh24_pkg::INIT_A ^ key_lo;
			vb = sh24_pkg::INIT_B ^ key_hi;
			vc = sh24_pkg::INIT_C ^ key_lo;
			vd = sh24_pkg::INIT_D ^ key_hi;
			byte_total = 8'd0;
			fold_block(chain);
		end
		byte_total = byte_total + {4'd0, n};
		if (!l) begin
			fold_block(m);
		end else begin
			// a full last word goes in whole; the length block then holds only the count
			if (n == 4'd8) begin
				fold_block(m);
				m = 64'd0;
			end
			fold_block(m | {byte_total, 56'd0});
			vc = vc ^ sh24_pkg::FINAL_XOR;
			repeat (4) sip_mix();
			expected_digests.push_back(va ^ vb ^ vc ^ vd);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo = 64'd0;
			key_hi = 64'd0;
			va = 64'd0;
			vb = 64'd0;
			vc = 64'd0;
			vd = 64'd0;
			byte_total = 8'd0;
			expected_digests.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == sh24_pkg::REG_KEY_LOW)
					key_lo = cfg_data;
				else
					key_hi = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_digests.size() == 0) begin
					report_mismatch($sformatf("digest %h with none expected", digest));
				end else begin
					want = expected_digests.pop_front();
					if (digest !== want)
						report_mismatch($sformatf("digest %h, expected %h", digest, want));
				end
			end
			if (in_valid && !in_stall)
				hash_word(first_word, chain_in, message_word, byte_count, last_word);
		end
		mismatches <= fail_count;
		digests_owed <= expected_digests.size();
	end

endmodule

`default_nettype wire

### tb/tb.sv
// tb: stimulus and verdict for the chained SipHash-2-4 engine; checking is
// done by sh24_digest_checker placed beside the engine. Depends on sh24_pkg.
`default_nettype none

module tb;

	localparam int          WORD_BUDGET = 1100;
	localparam int          DRAIN_PAD   = 24;   // longest word: chain + word + length + 4 final
	localparam int          LONG_HOLD   = 300;
	localparam int          QUIET_LIMIT = 4000;
	localparam logic [63:0] ONES        = {64{1'b1}};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = sh24_pkg::REG_KEY_LOW;
	logic [63:0] cfg_data = 64'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        first_word = 1'b0;
	logic [63:0] chain_in = 64'd0;
	logic [63:0] message_word = 64'd0;
	logic [3:0]  byte_count = 4'd0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] digest;

	int mismatches;
	int digests_owed;
	int words_sent = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b0;    // random gaps allowed on both sides
	bit calm = 1'b0;       // closing stretch: no gaps at all
	bit hold_req = 1'b0;   // ask the digest side for one long hold-off

	always #2 clk = ~clk;

	siphash24_chained_digest u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_word   (first_word),
		.chain_in     (chain_in),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest       (digest)
	);

	sh24_digest_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_word   (first_word),
		.chain_in     (chain_in),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest       (digest),
		.mismatches   (mismatches),
		.digests_owed (digests_owed)
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// chain values lean toward the extremes now and then
	function automatic logic [63:0] pick_chain();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return 64'd0;
		if (sel == 1)
			return ONES;
		return rand64();
	endfunction

	// Offer one word and hold it until the engine takes it. An optional gap
	// with valid low goes in front; valid never looks at stall.
	task automatic send_word(input logic f, input logic [63:0] ch, input logic [63:0] w,
			input logic [3:0] n, input logic l);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		first_word   <= f;
		chain_in     <= ch;
		message_word <= w;
		byte_count   <= n;
		last_word    <= l;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// One message: mostly full middle words and a last word of 0..8 bytes,
	// sometimes an oversized count. A long message now and then pushes the
	// byte counter past 255. Without a first word the message continues
	// from whatever the lanes hold; with short_middle a middle word may be
	// short or oversized too.
	task automatic send_message(input bit with_first, input bit short_middle);
		int         nw;
		logic [3:0] n;
		nw = ($urandom_range(0, 24) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 6);
		for (int i = 0; i < nw; i++) begin
			if (i == nw - 1)
				n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 8));
			else if (short_middle && $urandom_range(0, 2) == 0)
				n = 4'($urandom_range(0, 15));
			else
				n = 4'd8;
			send_word(with_first && i == 0, pick_chain(), rand64(), n, i == nw - 1);
		end
	endtask

	task automatic run_traffic(input int upto);
		int pick;
		while (words_sent < upto) begin
			idle_on = !calm && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 2)
				send_word(1'($urandom_range(0, 1)), rand64(), rand64(),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			else if (pick < 4)
				send_message(1'b0, 1'b0);
			else if (pick < 7)
				send_message(1'b1, 1'b1);
			else
				send_message(1'b1, 1'b0);
		end
	endtask

	// Drop valid, let the checker catch up on the last word, wait until
	// every digest is in, then give a word without a digest time to finish.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (digests_owed != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Write both key halves while the engine is idle; lower valid once at the end.
	task automatic load_keys(input logic [63:0] lo, input logic [63:0] hi);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= sh24_pkg::REG_KEY_LOW;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= sh24_pkg::REG_KEY_HIGH;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Digest side: random stall bursts while gaps are on, and one long
	// hold-off on request so the engine backs up into its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset key of all zeros.
		// No message started: lanes and counter still hold their reset zeros.
		send_word(1'b0, ONES, ONES, 4'd8, 1'b0);
		send_word(1'b0, 64'd0, rand64(), 4'd3, 1'b1);
		// Empty message: chain of zero, no bytes at all.
		send_word(1'b1, 64'd0, 64'd0, 4'd0, 1'b1);
		// Full last word: whole word absorbed, length block carries only the count.
		send_word(1'b1, ONES, ONES, 4'd8, 1'b1);
		// Short word not last, then an oversized count on the last word.
		send_word(1'b1, rand64(), ONES, 4'd5, 1'b0);
		send_word(1'b0, rand64(), ONES, 4'd15, 1'b1);
		// Oversized middle word, an empty middle word, then seven bytes.
		send_word(1'b1, 64'd0, rand64(), 4'd12, 1'b0);
		send_word(1'b0, 64'd0, rand64(), 4'd0, 1'b0);
		send_word(1'b0, ONES, rand64(), 4'd7, 1'b1);
		// Continue straight from the finalized lanes of the previous message.
		send_word(1'b0, 64'd0, ONES, 4'd1, 1'b1);
		send_word(1'b1, rand64(), 64'd0, 4'd9, 1'b0);
		send_word(1'b0, 64'd0, ONES, 4'd8, 1'b0);
		send_word(1'b0, 64'd0, rand64(), 4'd8, 1'b1);

		// Random phases, each under a new key; the sender pauses for every
		// digest before each key change.
		load_keys(ONES, ONES);
		run_traffic(WORD_BUDGET / 4);
		load_keys(rand64(), rand64());
		hold_req = 1'b1;
		run_traffic(WORD_BUDGET / 2);
		load_keys(64'd0, ONES);
		run_traffic(3 * WORD_BUDGET / 4);
		load_keys(rand64(), 64'd0);
		calm = 1'b1;
		idle_on = 1'b0;
		run_traffic(WORD_BUDGET);
		drain();

		if (mismatches == 0 && digests_owed == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
